// File: hw/rtl/rclh_pkg.sv
// Shared types and constants for the rectifier CAN link handler.
// Holds identifiers, mode and command codes, register indexes and the
// word, state, result and register structs. No dependencies.
package rclh_pkg;

   // Command codes carried by an input word
   typedef enum logic [1:0] {
      CMD_FRAME    = 2'd0,
      CMD_TICK     = 2'd1,
      CMD_STARTUP  = 2'd2,
      CMD_SETPOINT = 2'd3
   } command_type;

   // Supply modes
   localparam logic [2:0] MODE_NORMAL  = 3'd0;
   localparam logic [2:0] MODE_RAMPING = 3'd1;
   localparam logic [2:0] MODE_WARNING = 3'd2;
   localparam logic [2:0] MODE_ALARM   = 3'd3;
   localparam logic [2:0] MODE_OFF     = 3'd4;

   // Result kinds
   localparam logic KIND_FRAME  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   // Register indexes and widths
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINK_ENABLED    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPORTS_ENABLED = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SILENCE_TIMEOUT = 2'd2;
   localparam logic [15:0] SILENCE_TIMEOUT_RESET = 16'd1000;

   // Identifiers
   localparam logic [28:0] ID_LOGIN        = 29'h05004804;
   localparam logic [28:0] ID_ANNOUNCE     = 29'h05014400;
   localparam logic [12:0] ID_ANNOUNCE_HI  = 13'h0500;
   localparam logic [20:0] ID_STATUS_HI    = 21'h050140;
   localparam logic [28:0] ID_RAMPING      = 29'h05014010;
   localparam logic [28:0] ID_WARNING      = 29'h05014008;
   localparam logic [28:0] ID_ALARM        = 29'h0501400C;
   localparam logic [28:0] ID_DETAIL_REQ   = 29'h0501BFFC;
   localparam logic [28:0] ID_STARTUP      = 29'h05019C00;
   localparam logic [28:0] ID_SETPOINT     = 29'h05FF4004;

   // Fixed bytes of the startup frame, the report voltage limit and the OVP margin
   localparam logic [7:0]  STARTUP_BYTE0   = 8'h29;
   localparam logic [7:0]  STARTUP_BYTE1   = 8'h15;
   localparam logic [12:0] REPORT_DV_LIMIT = 13'd1000;
   localparam logic [15:0] OVP_MARGIN_CV   = 16'd200;
   // Reciprocal of ten for 16-bit operands: x / 10 == (x * 0xCCCD) >> 19
   localparam logic [15:0] RECIP_TEN       = 16'hCCCD;

   typedef struct packed {
      command_type command;
      logic [28:0] frame_id;
      logic [63:0] frame_data;
      logic [15:0] set_centivolts;
      logic [15:0] set_deciamps;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [28:0] tx_id;
      logic [3:0]  tx_len;
      logic [63:0] tx_data;
      logic [2:0]  supply_mode;
      logic [7:0]  intake_temp;
      logic [7:0]  outlet_temp;
      logic [15:0] report_deciamps;
      logic [12:0] report_decivolts;
      logic [15:0] mains_volts;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [47:0] serial_bytes;
      logic        serial_valid;
      logic [2:0]  held_mode;
      logic [15:0] held_deciamps;
      logic [12:0] held_decivolts;
      logic [15:0] quiet_ms;
   } state_type;

   typedef struct packed {
      logic        link_enabled;
      logic        reports_enabled;
      logic [15:0] silence_timeout_ms;
   } cfg_type;

endpackage

// File: hw/rtl/rclh_req_if.sv
// Input channel of the rectifier CAN link handler: valid/ready plus payload.
// No dependencies.
interface rclh_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [28:0] frame_id;
   logic [63:0] frame_data;
   logic [15:0] set_centivolts;
   logic [15:0] set_deciamps;

   modport source (
      output valid, command, frame_id, frame_data, set_centivolts, set_deciamps,
      input  ready
   );
   modport sink (
      input  valid, command, frame_id, frame_data, set_centivolts, set_deciamps,
      output ready
   );
endinterface

// File: hw/rtl/rclh_rsp_if.sv
// Result channel of the rectifier CAN link handler: valid/ready plus payload.
// No dependencies.
interface rclh_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [28:0] tx_id;
   logic [3:0]  tx_len;
   logic [63:0] tx_data;
   logic [2:0]  supply_mode;
   logic [7:0]  intake_temp;
   logic [7:0]  outlet_temp;
   logic [15:0] report_deciamps;
   logic [12:0] report_decivolts;
   logic [15:0] mains_volts;
   logic        last;

   modport source (
      output valid, kind, tx_id, tx_len, tx_data, supply_mode, intake_temp,
             outlet_temp, report_deciamps, report_decivolts, mains_volts, last,
      input  ready
   );
   modport sink (
      input  valid, kind, tx_id, tx_len, tx_data, supply_mode, intake_temp,
             outlet_temp, report_deciamps, report_decivolts, mains_volts, last,
      output ready
   );
endinterface

// File: hw/rtl/rclh_step.sv
// Combinational work for one word: frame sorting, status decode, tick
// supervision and setpoint frames. Produces up to two results and next state.
// Depends on rclh_pkg.
module rclh_step (
   input  rclh_pkg::item_type   item,
   input  rclh_pkg::state_type  st,
   input  rclh_pkg::cfg_type    cfg,
   output rclh_pkg::result_type res0,
   output rclh_pkg::result_type res1,
   output logic [1:0]           count,
   output rclh_pkg::state_type  st_next
);
   import rclh_pkg::*;

   function automatic result_type make_frame(logic [28:0] id, logic [3:0] len,
                                             logic [63:0] data);
      result_type r;
      r         = '0;
      r.kind    = KIND_FRAME;
      r.tx_id   = id;
      r.tx_len  = len;
      r.tx_data = data;
      return r;
   endfunction

   function automatic result_type make_report(logic [2:0] mode, logic [7:0] tin,
                                              logic [7:0] tout, logic [15:0] da,
                                              logic [12:0] dv, logic [15:0] mains);
      result_type r;
      r                  = '0;
      r.kind             = KIND_REPORT;
      r.supply_mode      = mode;
      r.intake_temp      = tin;
      r.outlet_temp      = tout;
      r.report_deciamps  = da;
      r.report_decivolts = dv;
      r.mains_volts      = mains;
      return r;
   endfunction

   // Field slices of a status frame
   logic [7:0]  tin;
   logic [7:0]  tout;
   logic [15:0] amps;
   logic [15:0] centivolts;
   logic [15:0] mains;
   logic [31:0] dv_product;
   logic [12:0] dv;
   logic        is_announce;
   logic        is_status;
   logic [47:0] serial_src;
   logic [15:0] quiet_inc;
   logic [15:0] ovp;

   assign tin        = item.frame_data[7:0];
   assign amps       = item.frame_data[23:8];
   assign centivolts = item.frame_data[39:24];
   assign mains      = item.frame_data[55:40];
   assign tout       = item.frame_data[63:56];

   // Divide centivolts by ten through the reciprocal
   assign dv_product = {16'd0, centivolts} * {16'd0, RECIP_TEN};
   assign dv         = dv_product[31:19];

   assign is_announce = (item.frame_id[28:16] == ID_ANNOUNCE_HI)
                        || (item.frame_id == ID_ANNOUNCE);
   assign is_status   = (item.frame_id[28:8] == ID_STATUS_HI) && st.serial_valid;
   assign serial_src  = (item.frame_id == ID_ANNOUNCE) ? item.frame_data[47:0]
                                                       : item.frame_data[55:8];
   assign quiet_inc   = (st.quiet_ms == 16'hFFFF) ? st.quiet_ms : st.quiet_ms + 16'd1;
   assign ovp         = item.set_centivolts + OVP_MARGIN_CV;

   always_comb begin
      logic [2:0]  mode;
      logic        warn;
      logic        changed;
      result_type  rep;
      mode    = MODE_NORMAL;
      warn    = 1'b0;
      changed = 1'b0;
      rep     = '0;
      res0    = '0;
      res1    = '0;
      count   = 2'd0;
      st_next = st;

      unique case (item.command)
         CMD_FRAME: begin
            st_next.quiet_ms = '0;
            if (is_announce) begin
               // Capture the serial once, answer with login every time
               if (!st.serial_valid) begin
                  st_next.serial_bytes = serial_src;
                  st_next.serial_valid = 1'b1;
               end
               res0  = make_frame(ID_LOGIN, 4'd8, {16'd0, st_next.serial_bytes});
               count = 2'd1;
            end else if (is_status) begin
               if (item.frame_id == ID_RAMPING) begin
                  mode = MODE_RAMPING;
               end
               if (item.frame_id == ID_WARNING || item.frame_id == ID_ALARM) begin
                  warn  = (item.frame_id == ID_WARNING);
                  res0  = make_frame(ID_DETAIL_REQ, 4'd3,
                                     {40'd0, 8'h00, (warn ? 8'h04 : 8'h08), 8'h08});
                  count = 2'd1;
                  mode  = warn ? MODE_WARNING : MODE_ALARM;
               end
               changed = (mode != st.held_mode) || (dv != st.held_decivolts)
                         || (amps != st.held_deciamps);
               // Report behind the optional detail request
               if (changed && cfg.reports_enabled && dv < REPORT_DV_LIMIT) begin
                  rep = make_report(mode, tin, tout, amps, dv, mains);
                  if (count == 2'd0) begin
                     res0 = rep;
                  end else begin
                     res1 = rep;
                  end
                  count = count + 2'd1;
               end
               st_next.held_mode      = mode;
               st_next.held_deciamps  = amps;
               st_next.held_decivolts = dv;
            end
         end
         CMD_TICK: begin
            st_next.quiet_ms = quiet_inc;
            if (cfg.link_enabled && st.held_mode != MODE_OFF
                && quiet_inc > cfg.silence_timeout_ms) begin
               st_next.held_mode = MODE_OFF;
               if (cfg.reports_enabled) begin
                  res0  = make_report(MODE_OFF, 8'd0, 8'd0, 16'd0, 13'd0, 16'd0);
                  count = 2'd1;
               end
            end
         end
         CMD_STARTUP: begin
            if (st.serial_valid) begin
               res0  = make_frame(ID_STARTUP, 4'd5,
                                  {24'd0, item.set_centivolts, 8'h00,
                                   STARTUP_BYTE1, STARTUP_BYTE0});
               count = 2'd1;
            end
         end
         CMD_SETPOINT: begin
            if (st.serial_valid) begin
               res0  = make_frame(ID_SETPOINT, 4'd8,
                                  {ovp, item.set_centivolts, item.set_centivolts,
                                   item.set_deciamps});
               count = 2'd1;
            end
         end
         default: begin
         end
      endcase

      // Mark the final result of this word
      if (count == 2'd1) begin
         res0.last = 1'b1;
      end else if (count == 2'd2) begin
         res1.last = 1'b1;
      end
   end

endmodule

// File: hw/rtl/rectifier_can_link_handler_unit.sv
// Rectifier CAN link handler, top level.
// A taken word is held in the input register, and its results in the result buffer.
// Throughput: one word per cycle while each word causes at most one result and the
// result side keeps up; a two-result word fills the two-entry buffer and stalls the next word.
// Reset (synchronous, active high) clears link state, registers and buffers;
// mode resets to power-off and the silence timeout to 1000 ms.
module rectifier_can_link_handler_unit (
   input  logic                                clock,
   input  logic                                reset,
   rclh_req_if.sink                            req_if,
   rclh_rsp_if.source                          rsp_if,
   input  logic                                csr_wr_en,
   input  logic [rclh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rclh_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import rclh_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff;
   state_type  state_ff, state_in;
   cfg_type    cfg_ff, cfg_in;
   result_type slot0_ff, slot1_ff;
   logic [1:0] cnt_ff, cnt_in;

   result_type step_res0, step_res1;
   logic [1:0] step_count;
   state_type  step_state;

   logic req_fire, rsp_fire, step_en;

   rclh_step u_step (
      .item    (item_ff),
      .st      (state_ff),
      .cfg     (cfg_ff),
      .res0    (step_res0),
      .res1    (step_res1),
      .count   (step_count),
      .st_next (step_state)
   );

   // Handshakes: process the held word once the buffer drains
   assign rsp_fire = rsp_if.valid && rsp_if.ready;
   assign step_en  = in_valid_ff && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_fire));
   assign req_if.ready = !in_valid_ff || step_en;
   assign req_fire = req_if.valid && req_if.ready;

   assign in_valid_in = req_fire ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);
   assign cnt_in      = step_en ? step_count : (rsp_fire ? cnt_ff - 2'd1 : cnt_ff);
   assign state_in    = step_en ? step_state : state_ff;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LINK_ENABLED:    cfg_in.link_enabled       = csr_wdata[0];
            CSR_REPORTS_ENABLED: cfg_in.reports_enabled    = csr_wdata[0];
            CSR_SILENCE_TIMEOUT: cfg_in.silence_timeout_ms = csr_wdata[15:0];
            default: begin
            end
         endcase
      end
   end

   // Hold control state, link state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= 2'd0;
         state_ff    <= '{serial_bytes:   '0,
                          serial_valid:   1'b0,
                          held_mode:      MODE_OFF,
                          held_deciamps:  '0,
                          held_decivolts: '0,
                          quiet_ms:       '0};
         cfg_ff      <= '{link_enabled:       1'b0,
                          reports_enabled:    1'b0,
                          silence_timeout_ms: SILENCE_TIMEOUT_RESET};
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         state_ff    <= state_in;
         cfg_ff      <= cfg_in;
      end
   end

   // Capture the input word and advance the result buffer
   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= '{command:        command_type'(req_if.command),
                      frame_id:       req_if.frame_id,
                      frame_data:     req_if.frame_data,
                      set_centivolts: req_if.set_centivolts,
                      set_deciamps:   req_if.set_deciamps};
      end
      if (step_en) begin
         slot0_ff <= step_res0;
         slot1_ff <= step_res1;
      end else if (rsp_fire) begin
         slot0_ff <= slot1_ff;
      end
   end

   // Drive the result channel from the buffer head
   assign rsp_if.valid            = (cnt_ff != 2'd0);
   assign rsp_if.kind             = slot0_ff.kind;
   assign rsp_if.tx_id            = slot0_ff.tx_id;
   assign rsp_if.tx_len           = slot0_ff.tx_len;
   assign rsp_if.tx_data          = slot0_ff.tx_data;
   assign rsp_if.supply_mode      = slot0_ff.supply_mode;
   assign rsp_if.intake_temp      = slot0_ff.intake_temp;
   assign rsp_if.outlet_temp      = slot0_ff.outlet_temp;
   assign rsp_if.report_deciamps  = slot0_ff.report_deciamps;
   assign rsp_if.report_decivolts = slot0_ff.report_decivolts;
   assign rsp_if.mains_volts      = slot0_ff.mains_volts;
   assign rsp_if.last             = slot0_ff.last;

endmodule

// File: bench/rectifier_can_link_handler_unit_tb.sv
// Testbench for the rectifier CAN link handler top level.
// Drives the word channel, checks each result against an in-bench predictor.
// Depends on rclh_pkg, rclh_req_if, rclh_rsp_if and the top level.
module rectifier_can_link_handler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rclh_pkg::*;

   localparam int unsigned LATENCY_PAD      = 8;
   localparam int unsigned DRAIN_LIMIT      = 20000;
   localparam int unsigned LONG_HOLD_CYCLES = 400;
   localparam int unsigned RANDOM_WORDS     = 1440;
   localparam int unsigned RANDOM_PHASES    = 6;
   localparam int unsigned LONG_QUIET_TICKS = 120;
   localparam int unsigned MAX_PRINTED      = 40;
   localparam logic [63:0] DETAIL_WARN_DATA  = 64'h0408;
   localparam logic [63:0] DETAIL_ALARM_DATA = 64'h0808;
   localparam logic [3:0]  LOGIN_LEN    = 4'd8;
   localparam logic [3:0]  DETAIL_LEN   = 4'd3;
   localparam logic [3:0]  STARTUP_LEN  = 4'd5;
   localparam logic [3:0]  SETPOINT_LEN = 4'd8;
   localparam logic [15:0] QUIET_MAX    = 16'hFFFF;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   rclh_req_if req_if();
   rclh_rsp_if rsp_if();

   rectifier_can_link_handler_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // Predictor copy of the link state and registers
   cfg_type     cfg_mirror;
   logic [47:0] serial_store;
   logic        serial_known;
   logic [2:0]  mode_seen;
   logic [15:0] amps_seen;
   logic [12:0] dv_seen;
   logic [15:0] quiet_count;
   logic [63:0] last_status_data;

   result_type  expected_results[$];

   int unsigned words_sent;
   int unsigned results_checked;
   int unsigned reports_seen;
   int unsigned error_count;

   // Handshake pacing
   bit          idle_enabled;
   int unsigned hold_requests  = 0;
   int unsigned hold_served    = 0;
   int unsigned long_hold_left = 0;
   int unsigned rsp_stall_left = 0;

   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic result_type frame_result(input logic [28:0] id, input logic [3:0] len,
                                               input logic [63:0] data);
      result_type r;
      r = '0;
      r.kind    = KIND_FRAME;
      r.tx_id   = id;
      r.tx_len  = len;
      r.tx_data = data;
      return r;
   endfunction

   function automatic result_type report_result(input logic [2:0] mode, input logic [7:0] tin,
                                                input logic [7:0] tout, input logic [15:0] da,
                                                input logic [12:0] dv, input logic [15:0] mains);
      result_type r;
      r = '0;
      r.kind             = KIND_REPORT;
      r.supply_mode      = mode;
      r.intake_temp      = tin;
      r.outlet_temp      = tout;
      r.report_deciamps  = da;
      r.report_decivolts = dv;
      r.mains_volts      = mains;
      return r;
   endfunction

   // Advance the link state by one word and queue the results it causes
   function automatic void predict_results(input item_type w);
      result_type  outs[$];
      logic [2:0]  mode;
      logic [15:0] amps;
      logic [15:0] cv;
      logic [15:0] ovp;
      logic [12:0] dv;
      logic [63:0] src;
      case (w.command)
         CMD_FRAME: begin
            quiet_count = '0;
            if (w.frame_id[28:16] == ID_ANNOUNCE_HI || w.frame_id == ID_ANNOUNCE) begin
               // capture the serial only on the first announce
               if (!serial_known) begin
                  src = (w.frame_id == ID_ANNOUNCE) ? w.frame_data : (w.frame_data >> 8);
                  serial_store = src[47:0];
                  serial_known = 1'b1;
               end
               outs.push_back(frame_result(ID_LOGIN, LOGIN_LEN, {16'h0000, serial_store}));
            end else if (w.frame_id[28:8] == ID_STATUS_HI && serial_known) begin
               amps = w.frame_data[23:8];
               cv   = w.frame_data[39:24];
               dv   = 13'(cv / 16'd10);
               mode = MODE_NORMAL;
               if (w.frame_id == ID_RAMPING) mode = MODE_RAMPING;
               if (w.frame_id == ID_WARNING) begin
                  mode = MODE_WARNING;
                  outs.push_back(frame_result(ID_DETAIL_REQ, DETAIL_LEN, DETAIL_WARN_DATA));
               end
               if (w.frame_id == ID_ALARM) begin
                  mode = MODE_ALARM;
                  outs.push_back(frame_result(ID_DETAIL_REQ, DETAIL_LEN, DETAIL_ALARM_DATA));
               end
               if ((mode != mode_seen || dv != dv_seen || amps != amps_seen)
                   && cfg_mirror.reports_enabled && dv < REPORT_DV_LIMIT) begin
                  outs.push_back(report_result(mode, w.frame_data[7:0], w.frame_data[63:56],
                                               amps, dv, w.frame_data[55:40]));
               end
               mode_seen = mode;
               amps_seen = amps;
               dv_seen   = dv;
            end
         end
         CMD_TICK: begin
            if (quiet_count != QUIET_MAX) quiet_count++;
            if (cfg_mirror.link_enabled && mode_seen != MODE_OFF
                && quiet_count > cfg_mirror.silence_timeout_ms) begin
               mode_seen = MODE_OFF;
               if (cfg_mirror.reports_enabled)
                  outs.push_back(report_result(MODE_OFF, '0, '0, '0, '0, '0));
            end
         end
         CMD_STARTUP: begin
            cv = w.set_centivolts;
            if (serial_known)
               outs.push_back(frame_result(ID_STARTUP, STARTUP_LEN,
                  {24'h0, cv, 8'h00, STARTUP_BYTE1, STARTUP_BYTE0}));
         end
         default: begin
            cv  = w.set_centivolts;
            ovp = cv + OVP_MARGIN_CV;
            if (serial_known)
               outs.push_back(frame_result(ID_SETPOINT, SETPOINT_LEN,
                  {ovp, cv, cv, w.set_deciamps}));
         end
      endcase
      if (outs.size() != 0) outs[outs.size()-1].last = 1'b1;
      foreach (outs[i]) expected_results.push_back(outs[i]);
   endfunction

   function automatic item_type make_word(input command_type c, input logic [28:0] id,
                                          input logic [63:0] data, input logic [15:0] cv,
                                          input logic [15:0] da);
      item_type w;
      w.command        = c;
      w.frame_id       = id;
      w.frame_data     = data;
      w.set_centivolts = cv;
      w.set_deciamps   = da;
      return w;
   endfunction

   // Status payload around a chosen voltage, other bytes random
   function automatic logic [63:0] status_data(input logic [15:0] cv);
      logic [15:0] amps;
      amps = $urandom_range(0, 1) ? 16'($urandom_range(0, 600)) : 16'($urandom);
      return {8'($urandom), 16'($urandom), cv, amps, 8'($urandom)};
   endfunction

   // Mostly well-formed traffic with random content, some noise
   function automatic item_type random_word();
      item_type    w;
      int unsigned pick;
      logic [15:0] cv;
      w = make_word(CMD_FRAME, 29'($urandom), {$urandom, $urandom},
                    16'($urandom), 16'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         case ($urandom_range(0, 4))
            0:       w.frame_id = ID_RAMPING;
            1:       w.frame_id = ID_WARNING;
            2:       w.frame_id = ID_ALARM;
            default: w.frame_id = {ID_STATUS_HI, 8'($urandom)};
         endcase
         cv = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 9999)) : 16'($urandom);
         if ($urandom_range(0, 3) == 0) w.frame_data = last_status_data;
         else w.frame_data = status_data(cv);
         last_status_data = w.frame_data;
      end else if (pick < 42) begin
         w.frame_id = $urandom_range(0, 1) ? ID_ANNOUNCE : {ID_ANNOUNCE_HI, 16'($urandom)};
      end else if (pick < 70) begin
         w.command = CMD_TICK;
      end else if (pick < 78) begin
         w.command = CMD_STARTUP;
      end else if (pick < 86) begin
         w.command = CMD_SETPOINT;
      end else if (pick >= 94) begin
         w.command = command_type'($urandom_range(0, 3));
      end
      return w;
   endfunction

   // Offer one word, hold it until taken, then predict
   task automatic send_word(input item_type w);
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.command        <= w.command;
      req_if.frame_id       <= w.frame_id;
      req_if.frame_data     <= w.frame_data;
      req_if.set_centivolts <= w.set_centivolts;
      req_if.set_deciamps   <= w.set_deciamps;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      predict_results(w);
      words_sent++;
   endtask

   // Drop valid, wait for every expected result, then let the pipeline empty
   task automatic drain();
      int unsigned waited;
      waited = 0;
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_results.size() != 0) begin
         flag_error($sformatf("%0d expected results never arrived", expected_results.size()));
         expected_results.delete();
      end
      repeat (LATENCY_PAD) @(posedge clock);
   endtask

   // Write all three registers back to back; upper bits of 1-bit registers are noise
   task automatic program_regs(input bit link, input bit reps, input logic [15:0] tmo);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_LINK_ENABLED;
      csr_wdata <= {15'($urandom), link};
      @(posedge clock);
      csr_index <= CSR_REPORTS_ENABLED;
      csr_wdata <= {15'($urandom), reps};
      @(posedge clock);
      csr_index <= CSR_SILENCE_TIMEOUT;
      csr_wdata <= tmo;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cfg_mirror.link_enabled       = link;
      cfg_mirror.reports_enabled    = reps;
      cfg_mirror.silence_timeout_ms = tmo;
   endtask

   // Status, setpoints and ticks before any serial is known give nothing
   task automatic test_before_login();
      drain();
      program_regs(1'b1, 1'b1, 16'd1);
      send_word(make_word(CMD_FRAME, {ID_STATUS_HI, 8'h00}, status_data(16'd500), '0, '0));
      send_word(make_word(CMD_FRAME, ID_WARNING, status_data(16'd500), '0, '0));
      send_word(make_word(CMD_STARTUP, '0, '0, 16'hFFFF, '0));
      send_word(make_word(CMD_SETPOINT, '0, '0, 16'hFFFF, 16'hFFFF));
      repeat (3) send_word(make_word(CMD_TICK, '0, '0, '0, '0));
      send_word(make_word(CMD_FRAME, 29'h0, '0, '0, '0));
      send_word(make_word(CMD_FRAME, 29'h1FFFFFFF, '1, '1, '1));
      drain();
   endtask

   // First announce captures the serial, later ones repeat it
   task automatic test_login();
      if ($urandom_range(0, 1))
         send_word(make_word(CMD_FRAME, ID_ANNOUNCE, {$urandom, $urandom}, '0, '0));
      else
         send_word(make_word(CMD_FRAME, {ID_ANNOUNCE_HI, 16'($urandom)},
                             {$urandom, $urandom}, '0, '0));
      send_word(make_word(CMD_FRAME, ID_ANNOUNCE, {$urandom, $urandom}, '0, '0));
      send_word(make_word(CMD_FRAME, {ID_ANNOUNCE_HI, 16'hFFFF}, '1, '0, '0));
      send_word(make_word(CMD_FRAME, {ID_ANNOUNCE_HI, 16'h0000}, '0, '0, '0));
      drain();
   endtask

   // Decode every mode, the voltage cutoff, the unchanged case and reports off
   task automatic test_status_reports();
      program_regs(1'b0, 1'b1, SILENCE_TIMEOUT_RESET);
      send_word(make_word(CMD_FRAME, {ID_STATUS_HI, 8'h00}, '0, '0, '0));
      send_word(make_word(CMD_FRAME, {ID_STATUS_HI, 8'h00}, '0, '0, '0));
      send_word(make_word(CMD_FRAME, ID_RAMPING, status_data(16'd9999), '0, '0));
      send_word(make_word(CMD_FRAME, {ID_STATUS_HI, 8'h01}, status_data(16'd10000), '0, '0));
      send_word(make_word(CMD_FRAME, ID_WARNING, '1, '0, '0));
      send_word(make_word(CMD_FRAME, ID_ALARM, status_data(16'd500), '0, '0));
      send_word(make_word(CMD_FRAME, {ID_STATUS_HI, 8'hFF}, 64'h00FF_FF00_0AFF_FF00, '0, '0));
      drain();
      program_regs(1'b0, 1'b0, SILENCE_TIMEOUT_RESET);
      send_word(make_word(CMD_FRAME, ID_RAMPING, status_data(16'd1234), '0, '0));
      send_word(make_word(CMD_FRAME, ID_WARNING, status_data(16'd4321), '0, '0));
      drain();
   endtask

   // Startup and operating setpoint frames at the field extremes
   task automatic test_setpoints();
      send_word(make_word(CMD_STARTUP, '0, '0, 16'h0000, 16'hFFFF));
      send_word(make_word(CMD_STARTUP, '1, '1, 16'hFFFF, 16'h0000));
      send_word(make_word(CMD_STARTUP, '0, '0, 16'($urandom), 16'($urandom)));
      send_word(make_word(CMD_SETPOINT, '0, '0, 16'hFFFF, 16'h0000));
      send_word(make_word(CMD_SETPOINT, '0, '0, 16'd65335, 16'hFFFF));
      send_word(make_word(CMD_SETPOINT, '0, '0, 16'h0000, 16'($urandom)));
      drain();
   endtask

   // Silence supervision with reports on, reports off and the link disabled
   task automatic test_silence_timeout();
      program_regs(1'b1, 1'b1, 16'd1);
      send_word(make_word(CMD_FRAME, {ID_STATUS_HI, 8'h20}, status_data(16'd2400), '0, '0));
      repeat (3) send_word(make_word(CMD_TICK, '0, '0, '0, '0));
      drain();
      program_regs(1'b1, 1'b0, 16'd2);
      send_word(make_word(CMD_FRAME, ID_RAMPING, status_data(16'd2400), '0, '0));
      repeat (4) send_word(make_word(CMD_TICK, '0, '0, '0, '0));
      drain();
      program_regs(1'b0, 1'b1, 16'd1);
      send_word(make_word(CMD_FRAME, {ID_STATUS_HI, 8'h20}, status_data(16'd2400), '0, '0));
      repeat (5) send_word(make_word(CMD_TICK, '0, '0, '0, '0));
      drain();
   endtask

   // Quiet time keeps counting while the link is disabled: one enabled tick trips at once
   task automatic test_long_quiet();
      idle_enabled = 1'b0;
      program_regs(1'b0, 1'b1, 16'd100);
      send_word(make_word(CMD_FRAME, {ID_STATUS_HI, 8'h00}, status_data(16'd700), '0, '0));
      repeat (LONG_QUIET_TICKS) send_word(make_word(CMD_TICK, '0, '0, '0, '0));
      drain();
      program_regs(1'b1, 1'b1, 16'd100);
      send_word(make_word(CMD_TICK, '0, '0, '0, '0));
      drain();
      program_regs(1'b1, 1'b1, 16'hFFFF);
      send_word(make_word(CMD_FRAME, {ID_STATUS_HI, 8'h00}, status_data(16'd700), '0, '0));
      drain();
      idle_enabled = 1'b1;
   endtask

   // Hold off the result side for a long stretch while words keep coming
   task automatic test_backpressure();
      hold_requests++;
      for (int i = 0; i < 48; i++) begin
         case (i % 3)
            0:       send_word(make_word(CMD_SETPOINT, '0, '0, 16'($urandom), 16'($urandom)));
            1:       send_word(make_word(CMD_FRAME, ID_WARNING,
                                         status_data(16'($urandom_range(0, 9999))), '0, '0));
            default: send_word(make_word(CMD_FRAME, ID_ALARM,
                                         status_data(16'($urandom_range(0, 9999))), '0, '0));
         endcase
      end
      drain();
   endtask

   // Random traffic over several register settings; last phase runs without idling
   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         case (phase)
            0: program_regs(1'b1, 1'b1, 16'($urandom_range(1, 8)));
            1: program_regs(1'b0, 1'b1, SILENCE_TIMEOUT_RESET);
            2: program_regs(1'b1, 1'b0, 16'($urandom_range(1, 4)));
            3: program_regs(1'b1, 1'b1, 16'hFFFF);
            4: program_regs(1'b1, 1'b1, 16'd1);
            default: begin
               program_regs(1'b1, 1'b1, 16'($urandom_range(1, 20)));
               idle_enabled = 1'b0;
            end
         endcase
         repeat (RANDOM_WORDS / RANDOM_PHASES) send_word(random_word());
      end
      drain();
   endtask

   // Count down a long receiver hold-off once requested
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         long_hold_left <= LONG_HOLD_CYCLES;
         hold_served    <= hold_requests;
      end else if (long_hold_left != 0) begin
         long_hold_left <= long_hold_left - 1;
      end
   end

   // Drive result ready with random stall bursts
   always @(posedge clock) begin
      if (long_hold_left != 0) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_if.ready   <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 11) == 0) begin
         rsp_stall_left <= $urandom_range(1, 16) - 1;
         rsp_if.ready   <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Compare each taken result with the oldest expectation
   always @(posedge clock) begin : result_check
      result_type got;
      result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.kind             = rsp_if.kind;
         got.tx_id            = rsp_if.tx_id;
         got.tx_len           = rsp_if.tx_len;
         got.tx_data          = rsp_if.tx_data;
         got.supply_mode      = rsp_if.supply_mode;
         got.intake_temp      = rsp_if.intake_temp;
         got.outlet_temp      = rsp_if.outlet_temp;
         got.report_deciamps  = rsp_if.report_deciamps;
         got.report_decivolts = rsp_if.report_decivolts;
         got.mains_volts      = rsp_if.mains_volts;
         got.last             = rsp_if.last;
         results_checked++;
         if (got.kind === KIND_REPORT) reports_seen++;
         if (expected_results.size() == 0) begin
            flag_error($sformatf("result %0d not expected: kind %0d id %h mode %0d",
                                 results_checked, got.kind, got.tx_id, got.supply_mode));
         end else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind)
               flag_error($sformatf("result %0d kind %0d, want %0d",
                                    results_checked, got.kind, want.kind));
            if (got.tx_id !== want.tx_id)
               flag_error($sformatf("result %0d tx_id %h, want %h",
                                    results_checked, got.tx_id, want.tx_id));
            if (got.tx_len !== want.tx_len)
               flag_error($sformatf("result %0d tx_len %0d, want %0d",
                                    results_checked, got.tx_len, want.tx_len));
            if (got.tx_data !== want.tx_data)
               flag_error($sformatf("result %0d tx_data %h, want %h",
                                    results_checked, got.tx_data, want.tx_data));
            if (got.supply_mode !== want.supply_mode)
               flag_error($sformatf("result %0d supply_mode %0d, want %0d",
                                    results_checked, got.supply_mode, want.supply_mode));
            if (got.intake_temp !== want.intake_temp)
               flag_error($sformatf("result %0d intake_temp %0d, want %0d",
                                    results_checked, got.intake_temp, want.intake_temp));
            if (got.outlet_temp !== want.outlet_temp)
               flag_error($sformatf("result %0d outlet_temp %0d, want %0d",
                                    results_checked, got.outlet_temp, want.outlet_temp));
            if (got.report_deciamps !== want.report_deciamps)
               flag_error($sformatf("result %0d report_deciamps %0d, want %0d",
                                    results_checked, got.report_deciamps,
                                    want.report_deciamps));
            if (got.report_decivolts !== want.report_decivolts)
               flag_error($sformatf("result %0d report_decivolts %0d, want %0d",
                                    results_checked, got.report_decivolts,
                                    want.report_decivolts));
            if (got.mains_volts !== want.mains_volts)
               flag_error($sformatf("result %0d mains_volts %0d, want %0d",
                                    results_checked, got.mains_volts, want.mains_volts));
            if (got.last !== want.last)
               flag_error($sformatf("result %0d last %0d, want %0d",
                                    results_checked, got.last, want.last));
         end
      end
   end

   // Stop a hung run
   initial begin
      #(30_000_000);
      $display("TB_ERROR");
      $finish;
   end

   // Reset once, then run the tests in turn
   initial begin
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_if.valid          = 1'b0;
      req_if.command        = '0;
      req_if.frame_id       = '0;
      req_if.frame_data     = '0;
      req_if.set_centivolts = '0;
      req_if.set_deciamps   = '0;
      cfg_mirror.link_enabled       = 1'b0;
      cfg_mirror.reports_enabled    = 1'b0;
      cfg_mirror.silence_timeout_ms = SILENCE_TIMEOUT_RESET;
      serial_store     = '0;
      serial_known     = 1'b0;
      mode_seen        = MODE_OFF;
      amps_seen        = '0;
      dv_seen          = '0;
      quiet_count      = '0;
      last_status_data = '0;
      words_sent       = 0;
      results_checked  = 0;
      reports_seen     = 0;
      error_count      = 0;
      idle_enabled     = 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_before_login();
      test_login();
      test_status_reports();
      test_setpoints();
      test_silence_timeout();
      test_long_quiet();
      test_backpressure();
      test_random_traffic();

      $display("Sent %0d words and checked %0d results (%0d status reports).",
               words_sent, results_checked, reports_seen);
      $display("Covered login, status decode, setpoints, silence power-off and backpressure.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/rclh_pkg.sv
hw/rtl/rclh_req_if.sv
hw/rtl/rclh_rsp_if.sv
hw/rtl/rclh_step.sv
hw/rtl/rectifier_can_link_handler_unit.sv
bench/rectifier_can_link_handler_unit_tb.sv
